/* src/saturation_adjust_rgb_macros.svh */
// Assertion helpers used by the checker file.
`ifndef SATURATION_ADJUST_RGB_MACROS_SVH
`define SATURATION_ADJUST_RGB_MACROS_SVH

// Property that is checked on every rising clock edge outside reset.
`define SAR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication that is checked on every rising clock edge outside reset.
`define SAR_ASSERT_IMP(label, pre, post, msg) \
    `SAR_ASSERT(label, (pre) |-> (post), msg)

`endif

/* src/sar_pkg.sv */
package sar_pkg;

    // Number of quotient bits that the divider resolves, one per stage.
    localparam int DIV_STEPS = 8;

    // Register stages from input to output: five arithmetic, then the divider.
    localparam int PIPE_DEPTH = 5 + DIV_STEPS;

    localparam int LANES = 3;

    // Remainder width; the dividend stays below 256 times the divisor.
    localparam int REM_W = 17;

    // Limits of the percent register.
    localparam logic signed [7:0] PCT_MIN = -8'sd100;
    localparam logic signed [7:0] PCT_MAX = 8'sd100;

    // One color lane as it moves through the divider stages.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [7:0]       quo;
        logic             zero;
        logic             full;
    } div_lane_t;

endpackage

/* src/saturation_adjust_rgb.sv */
// Saturation adjustment of an RGB pixel stream.
// The slave stream s_axis carries one pixel per word; the master stream m_axis
// carries the adjusted pixel. Both pack red in bits 7:0, green in 15:8 and
// blue in 23:16. The cfg channel writes the signed saturation change in
// percent; values beyond -100 and 100 are taken as those limits. Write it
// only while no pixel is in flight; cfg_ready is always high.
// Every pixel gives exactly one output word: five stages of min/max, gain
// selection, multiply and add, then eight restoring divider stages that each
// resolve one quotient bit. A new pixel is accepted in every cycle in which
// the pipeline is not held; the pipeline moves as a whole.
// When the receiver holds m_axis_tready low with a word waiting, the whole
// pipeline holds and s_axis_tready falls in the same cycle; nothing is lost
// or repeated, and bubbles inside the pipeline stay where they are.
// Reset clears all valid bits and sets the percent register to zero.
module saturation_adjust_rgb
    import sar_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // in_red, in_green, in_blue
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // out_red, out_green, out_blue
);

    logic signed [7:0] pct_reg;
    logic              en;

    // Stage valid bits.
    logic [4:0]           vld_reg;
    logic [DIV_STEPS-1:0] dvld_reg;

    // Stage 1: channels, extremes and clamped percent.
    logic [7:0]        ch1_reg [LANES];
    logic [8:0]        sum1_reg;
    logic [7:0]        diff1_reg;
    logic signed [7:0] pct1_reg;

    // Stage 2: gain as numerator and denominator, centered channels.
    logic [7:0]         ch2_reg [LANES];
    logic signed [10:0] ctr2_reg [LANES];
    logic signed [9:0]  gn2_reg;
    logic [7:0]         gd2_reg;

    // Stage 3: products.
    logic [16:0]        t1_reg [LANES];
    logic signed [20:0] t2_reg [LANES];
    logic [7:0]         gd3_reg;

    // Stage 4: dividend and divisor.
    logic signed [19:0] num4_reg [LANES];
    logic [8:0]         dv4_reg;

    // Stage 5 and divider stages.
    div_lane_t  d5_reg [LANES];
    logic [8:0] dv5_reg;
    div_lane_t  dl_reg [DIV_STEPS][LANES];
    logic [8:0] dv_reg [DIV_STEPS];

    // Percent register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pct_reg <= '0;
        else if (cfg_valid)
            pct_reg <= $signed(cfg_data);
    end

    // The pipeline moves when the output word is empty or taken.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            dvld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg  <= {vld_reg[3:0], s_axis_tvalid};
            dvld_reg <= {dvld_reg[DIV_STEPS-2:0], vld_reg[4]};
        end
    end

    // Stage 1: largest and smallest channel, and the clamped percent.
    logic [7:0]        mx1_c, mn1_c;
    logic signed [7:0] pct1_c;
    always_comb
    begin
        mx1_c = s_axis_tdata[7:0];
        mn1_c = s_axis_tdata[7:0];
        for (int i = 1; i < LANES; i++)
        begin
            if (s_axis_tdata[8*i +: 8] > mx1_c) mx1_c = s_axis_tdata[8*i +: 8];
            if (s_axis_tdata[8*i +: 8] < mn1_c) mn1_c = s_axis_tdata[8*i +: 8];
        end
        if (pct_reg < PCT_MIN)
            pct1_c = PCT_MIN;
        else if (pct_reg > PCT_MAX)
            pct1_c = PCT_MAX;
        else
            pct1_c = pct_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
                ch1_reg[i] <= s_axis_tdata[8*i +: 8];
            sum1_reg  <= {1'b0, mx1_c} + {1'b0, mn1_c};
            diff1_reg <= mx1_c - mn1_c;
            pct1_reg  <= pct1_c;
        end
    end

    // Stage 2: pick the gain gn/gd. Fading is gn = p over gd = 100, a grey
    // pixel uses a zero gain, and a boost compares p/100 + S against one.
    logic [7:0]        den2_c;
    logic [6:0]        pu2_c;
    logic [16:0]       lhs2_c, rhs2_c;
    logic signed [9:0] gn2_c;
    logic [7:0]        gd2_c;
    always_comb
    begin
        den2_c = (sum1_reg < 9'd255) ? sum1_reg[7:0] : 8'(10'd510 - {1'b0, sum1_reg});
        pu2_c  = pct1_reg[6:0];
        lhs2_c = 17'(pu2_c) * 17'(den2_c) + 17'd100 * 17'(diff1_reg);
        rhs2_c = 17'd100 * 17'(den2_c);
        if (diff1_reg == 8'd0)
        begin
            gn2_c = '0;
            gd2_c = 8'd1;
        end
        else if (pct1_reg < 0)
        begin
            gn2_c = 10'(pct1_reg);
            gd2_c = 8'd100;
        end
        else if (lhs2_c >= rhs2_c)
        begin
            gn2_c = $signed({2'b00, den2_c - diff1_reg});
            gd2_c = diff1_reg;
        end
        else
        begin
            gn2_c = $signed({3'b000, pu2_c});
            gd2_c = 8'd100 - {1'b0, pu2_c};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                ch2_reg[i]  <= ch1_reg[i];
                ctr2_reg[i] <= $signed({2'b00, ch1_reg[i], 1'b0}) - $signed({2'b00, sum1_reg});
            end
            gn2_reg <= gn2_c;
            gd2_reg <= gd2_c;
        end
    end

    // Stage 3: 2c*gd and (2c - s)*gn.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                t1_reg[i] <= 17'({ch2_reg[i], 1'b0}) * 17'(gd2_reg);
                t2_reg[i] <= 21'(ctr2_reg[i]) * 21'(gn2_reg);
            end
            gd3_reg <= gd2_reg;
        end
    end

    // Stage 4: dividend and divisor 2*gd.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
                num4_reg[i] <= $signed({3'b000, t1_reg[i]}) + t2_reg[i][19:0];
            dv4_reg <= {gd3_reg, 1'b0};
        end
    end

    // Stage 5: a negative dividend clamps to zero, a quotient of 256 or more
    // clamps to 255; otherwise the remainder enters the divider.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                d5_reg[i].zero <= num4_reg[i][19];
                d5_reg[i].full <= !num4_reg[i][19] &&
                                  (num4_reg[i][18:0] >= 19'({dv4_reg, 8'b0}));
                d5_reg[i].rem  <= num4_reg[i][REM_W-1:0];
                d5_reg[i].quo  <= '0;
            end
            dv5_reg <= dv4_reg;
        end
    end

    // One restoring step: try to take the shifted divisor off the remainder.
    function automatic div_lane_t div_step(div_lane_t lane, logic [8:0] dv, int sh);
        div_lane_t        res;
        logic [REM_W-1:0] step;
        res  = lane;
        step = REM_W'(dv) << sh;
        if (lane.rem >= step)
        begin
            res.rem     = lane.rem - step;
            res.quo[sh] = 1'b1;
        end
        return res;
    endfunction

    // Divider: each stage resolves one quotient bit, most significant first.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
                dl_reg[0][i] <= div_step(d5_reg[i], dv5_reg, DIV_STEPS - 1);
            dv_reg[0] <= dv5_reg;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                for (int i = 0; i < LANES; i++)
                    dl_reg[k][i] <= div_step(dl_reg[k-1][i], dv_reg[k-1], DIV_STEPS - 1 - k);
                dv_reg[k] <= dv_reg[k-1];
            end
        end
    end

    // Output word from the last divider stage.
    assign m_axis_tvalid = dvld_reg[DIV_STEPS-1];
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (dl_reg[DIV_STEPS-1][i].zero)
                m_axis_tdata[8*i +: 8] = 8'd0;
            else if (dl_reg[DIV_STEPS-1][i].full)
                m_axis_tdata[8*i +: 8] = 8'd255;
            else
                m_axis_tdata[8*i +: 8] = dl_reg[DIV_STEPS-1][i].quo;
        end
    end

endmodule

/* src/sar_checker.sv */
`include "saturation_adjust_rgb_macros.svh"

module sar_checker
    import sar_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata
);

    logic [4:0] inflight_reg;
    logic       in_acc, out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Words accepted whose result has not yet been taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_reg + 5'(in_acc) - 5'(out_acc);
    end

    `SAR_ASSERT(a_depth, inflight_reg <= 5'(PIPE_DEPTH), "more words in flight than stages")
    `SAR_ASSERT_IMP(a_no_phantom, m_axis_tvalid, inflight_reg != 5'd0, "output word without input")
    `SAR_ASSERT_IMP(a_stall_blocks, m_axis_tvalid && !m_axis_tready, !s_axis_tready,
        "input taken while output stalled")
    `SAR_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata)), "stalled output word changed")

endmodule

bind saturation_adjust_rgb sar_checker u_sar_checker (.*);

/* test/saturation_adjust_rgb_tb.sv */
module saturation_adjust_rgb_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sar_pkg::*;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // A pending word is a pixel, a drain that waits for an idle pipeline, or a percent setting applied while idle.
    typedef enum logic [1:0] {JOB_PIXEL, JOB_SETTING, JOB_DRAIN} job_kind_t;

    typedef struct {
        job_kind_t    kind;
        pixel_t       pix;
        logic [7:0]   pct;
    } job_t;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = PIPE_DEPTH + 10;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    job_t   job_queue[$];
    pixel_t expected_pixels[$];
    logic signed [7:0] model_pct;
    int     mismatch_count;
    int     cycle_count;
    bit     stimulus_done;
    bit     quiet_tail;
    int     send_gap;
    int     recv_gap;
    int     settle_count;

    saturation_adjust_rgb dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] clamp_byte(longint v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    // Exact rational adjustment of one pixel, truncated toward zero.
    function automatic pixel_t adjust_pixel(pixel_t pix, logic signed [7:0] pct_reg);
        longint ch[3];
        longint mx, mn, d, s, den, p, gn, gd, num;
        logic [7:0] res[3];
        pixel_t r;
        ch[0] = pix.red;
        ch[1] = pix.green;
        ch[2] = pix.blue;
        mx = ch[0];
        mn = ch[0];
        for (int i = 1; i < 3; i++)
        begin
            if (ch[i] > mx) mx = ch[i];
            if (ch[i] < mn) mn = ch[i];
        end
        d = mx - mn;
        s = mx + mn;
        p = pct_reg;
        if (p < -100) p = -100;
        if (p > 100) p = 100;
        if (d == 0)
            return pix;
        den = (s < 255) ? s : 510 - s;
        for (int i = 0; i < 3; i++)
        begin
            if (p >= 0)
            begin
                if (p * den + 100 * d >= 100 * den)
                begin
                    gn = den - d;
                    gd = d;
                end
                else
                begin
                    gn = p;
                    gd = 100 - p;
                end
                num = 2 * ch[i] * gd + (2 * ch[i] - s) * gn;
                res[i] = clamp_byte(num / (2 * gd));
            end
            else
            begin
                num = 100 * s + (2 * ch[i] - s) * (100 + p);
                res[i] = clamp_byte(num / 200);
            end
        end
        r.red = res[0];
        r.green = res[1];
        r.blue = res[2];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        job_t j;
        j.kind = JOB_PIXEL;
        j.pix = '{blue: b, green: g, red: r};
        j.pct = '0;
        job_queue.push_back(j);
    endtask

    task automatic add_setting(logic [7:0] v);
        job_t j;
        j.kind = JOB_DRAIN;
        j.pix = '0;
        j.pct = '0;
        job_queue.push_back(j);
        j.kind = JOB_SETTING;
        j.pct = v;
        job_queue.push_back(j);
    endtask

    function automatic pixel_t random_pixel();
        pixel_t px;
        int mode;
        mode = $urandom_range(0, 5);
        px = 24'($urandom);
        if (mode == 0)
        begin
            // Grey or nearly grey pixels.
            px.green = px.red;
            px.blue = 8'(px.red + $urandom_range(0, 1));
        end
        else if (mode == 1)
        begin
            // Red and blue channels pinned at the rails.
            px.red = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            px.blue = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
        return px;
    endfunction

    // Stimulus: directed pixels at the first three settings, random pixels at each, then random phases.
    initial
    begin
        logic [7:0] settings[$];
        logic [7:0] v;
        settings = '{8'd0, 8'd100, 8'h9C, 8'd127, 8'h80, 8'd50, 8'hCE, 8'd99, 8'hFF, 8'd1};
        foreach (settings[k])
        begin
            add_setting(settings[k]);
            if (k < 3)
            begin
                add_pixel(8'd0, 8'd0, 8'd0);
                add_pixel(8'd255, 8'd255, 8'd255);
                add_pixel(8'd255, 8'd0, 8'd0);
                add_pixel(8'd0, 8'd255, 8'd128);
                add_pixel(8'd200, 8'd100, 8'd50);
                add_pixel(8'd10, 8'd20, 8'd30);
                add_pixel(8'd240, 8'd250, 8'd245);
                add_pixel(8'd127, 8'd128, 8'd128);
            end
            for (int i = 0; i < 50; i++)
                job_queue.push_back('{JOB_PIXEL, random_pixel(), 8'd0});
        end
        // Random settings, including raw byte values beyond the clamp limits.
        for (int ph = 0; ph < 4; ph++)
        begin
            v = (ph == 3) ? 8'(100 - $urandom_range(0, 200)) : 8'($urandom);
            add_setting(v);
            for (int i = 0; i < 10; i++)
                job_queue.push_back('{JOB_PIXEL, random_pixel(), 8'd0});
        end
    end

    // Reset at the start of the run.
    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: pixels and register writes from the pending queue.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            cfg_valid     <= 1'b0;
            cfg_data      <= '0;
            model_pct     <= '0;
            send_gap      <= 0;
            stimulus_done <= 1'b0;
            quiet_tail    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cfg_valid <= 1'b0;
            else if (s_axis_tvalid && !s_axis_tready)
                ;
            else if (cfg_valid)
                ;
            else if (send_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (job_queue.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                stimulus_done <= 1'b1;
            end
            else if (job_queue[0].kind == JOB_DRAIN)
            begin
                // Hold off until the pipeline has emptied out.
                s_axis_tvalid <= 1'b0;
                if (expected_pixels.size() == 0 && !s_axis_tvalid)
                begin
                    if (settle_count >= SETTLE_CYCLES)
                        void'(job_queue.pop_front());
                end
            end
            else if (job_queue[0].kind == JOB_SETTING)
            begin
                s_axis_tvalid <= 1'b0;
                cfg_valid <= 1'b1;
                cfg_data <= job_queue[0].pct;
                model_pct <= job_queue[0].pct;
                void'(job_queue.pop_front());
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap <= $urandom_range(0, 6);
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= job_queue[0].pix;
                expected_pixels.push_back(adjust_pixel(job_queue[0].pix, model_pct));
                void'(job_queue.pop_front());
                if (job_queue.size() < 40)
                    quiet_tail <= 1'b1;
            end
        end
    end

    // Count idle cycles with nothing outstanding, used before register writes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_count <= 0;
        else if (expected_pixels.size() != 0 || s_axis_tvalid)
            settle_count <= 0;
        else
            settle_count <= settle_count + 1;
    end

    // Monitor: receiver stalls and checks of each output word.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t got;
        pixel_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
            mismatch_count = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_pixels.size() == 0)
                    report_mismatch($sformatf("output word with no pixel outstanding: %h", got));
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.red !== want.red)
                        report_mismatch($sformatf("red: got %0d, expected %0d",
                            got.red, want.red));
                    if (got.green !== want.green)
                        report_mismatch($sformatf("green: got %0d, expected %0d",
                            got.green, want.green));
                    if (got.blue !== want.blue)
                        report_mismatch($sformatf("blue: got %0d, expected %0d",
                            got.blue, want.blue));
                end
            end
            if (recv_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                recv_gap <= $urandom_range(0, 6);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // End of run: drain, settle, then the verdict; a run past the cycle limit fails.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("Regression FAIL");
                $finish;
            end
            if (stimulus_done && expected_pixels.size() == 0 && settle_count > SETTLE_CYCLES)
            begin
                if (mismatch_count == 0)
                    $display("Regression PASS");
                else
                    $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule
